// File: hw/rtl/fies_pkg.sv
package fies_pkg;

  localparam int SLOTS       = 8;
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [31:0] EMPTY_WORD          = 32'hFFFF_FFFF;
  localparam logic [5:0]  WARM_RESET_ID       = 6'h03;
  localparam logic [7:0]  PROFILE_NONE        = 8'hFF;
  localparam logic [3:0]  STATUS_QUALIFIED    = 4'hA;
  localparam logic [3:0]  STATUS_DISQUALIFIED = 4'h0;
  localparam logic [3:0]  TYPE_INSTANT        = 4'h1;
  localparam logic [3:0]  TYPE_AFTER_TIME     = 4'h2;
  localparam logic [3:0]  TYPE_AFTER_CYCLE    = 4'h3;
  localparam logic        KIND_WRITE          = 1'b0;
  localparam logic        KIND_TICK           = 1'b1;

  typedef enum logic [1:0] {
    OUT_FAILED = 2'd0,
    OUT_PASSED = 2'd1,
    OUT_HALT   = 2'd2
  } outcome_e;

  typedef struct packed {
    logic        kind;
    logic [2:0]  slot;
    logic [31:0] command_word;
    logic [31:0] check_word;
    logic [7:0]  profile_a;
    logic [7:0]  profile_b;
    logic [7:0]  profile_c;
    logic [7:0]  profile_d;
    logic [7:0]  profile_e;
    logic [7:0]  profile_f;
  } item_t;

  typedef struct packed {
    logic [5:0] event_id;
    outcome_e   outcome;
    logic [2:0] source_slot;
    logic       last;
  } report_t;

  // walk token handed from cell to cell
  typedef struct packed {
    logic vld;
    logic active;
  } token_t;

  typedef struct packed {
    logic        en;
    logic [31:0] cmd;
    logic [31:0] chk;
  } slot_wr_t;

  typedef struct packed {
    logic       vld;
    outcome_e   outcome;
    logic [5:0] id;
  } cell_rpt_t;

endpackage

// File: hw/rtl/fies_intf.sv
interface fies_item_if
  import fies_pkg::*;
();
  logic  valid;
  logic  ready;
  item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface fies_rpt_if
  import fies_pkg::*;
();
  logic    valid;
  logic    ready;
  report_t rpt;

  modport source (output valid, output rpt, input ready);
  modport sink   (input valid, input rpt, output ready);
endinterface

// File: hw/rtl/fies_cell.sv
module fies_cell
  import fies_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      shift_i,
  input  slot_wr_t  wr_i,
  input  token_t    tok_i,
  output token_t    tok_o,
  output cell_rpt_t rpt_o
);

  logic [31:0] cmd_q, chk_q;
  logic [15:0] dly_q, dly_d, cyc_q, cyc_d;
  token_t      tok_q;

  logic        slot_ok;
  logic [3:0]  status, kind;
  logic [15:0] tm, tm_m1, dly_inc, cyc_inc;
  logic        dly_hit, cyc_hit, fire;

  assign slot_ok = (cmd_q != EMPTY_WORD) && ((cmd_q ^ chk_q) == EMPTY_WORD);
  assign status  = cmd_q[11:8];
  assign kind    = cmd_q[15:12];
  assign tm      = cmd_q[31:16];
  assign tm_m1   = tm - 16'd1;
  assign dly_inc = dly_q + 16'd1;
  assign cyc_inc = cyc_q + 16'd1;
  assign dly_hit = (dly_inc == tm);
  assign cyc_hit = (cyc_inc == tm);

  always_comb begin
    fire  = 1'b0;
    dly_d = dly_q;
    cyc_d = cyc_q;
    rpt_o = '{vld: 1'b0, outcome: OUT_FAILED, id: cmd_q[5:0]};
    if (tok_q.vld && slot_ok) begin
      if (status == STATUS_QUALIFIED) begin
        case (kind)
          TYPE_INSTANT: fire = 1'b1;
          TYPE_AFTER_TIME: begin
            fire  = dly_hit;
            dly_d = dly_hit ? tm_m1 : dly_inc;
          end
          TYPE_AFTER_CYCLE: begin
            if (tok_q.active) begin
              fire  = cyc_hit;
              cyc_d = cyc_hit ? tm_m1 : cyc_inc;
            end
          end
          default: ;
        endcase
        if (fire) begin
          rpt_o.vld     = 1'b1;
          rpt_o.outcome = (cmd_q[5:0] == WARM_RESET_ID) ? OUT_HALT : OUT_FAILED;
        end
      end else if (status == STATUS_DISQUALIFIED) begin
        rpt_o.vld     = 1'b1;
        rpt_o.outcome = OUT_PASSED;
        dly_d         = '0;
      end
    end
  end

  // a warm reset halt stops the token here
  assign tok_o.vld    = tok_q.vld && !(rpt_o.vld && (rpt_o.outcome == OUT_HALT));
  assign tok_o.active = tok_q.active;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= EMPTY_WORD;
      chk_q <= '0;
      dly_q <= '0;
      cyc_q <= '0;
      tok_q <= '0;
    end else begin
      if (wr_i.en) begin
        cmd_q <= wr_i.cmd;
        chk_q <= wr_i.chk;
      end
      if (shift_i) begin
        tok_q <= tok_i;
        if (tok_q.vld) begin
          dly_q <= dly_d;
          cyc_q <= cyc_d;
        end
      end
    end
  end

endmodule

// File: hw/rtl/fault_injection_event_scheduler.sv
// Channel | Dir | Payload                                  | Transfer
// in_i    | in  | kind, slot, command/check word, profiles | valid & ready
// res_o   | out | event_id, outcome, source_slot, last     | valid & ready
//
// A write goes straight into its slot cell. A tick walks a token down the row of SLOTS slot
// cells, one cell per cycle, then the walk ends in a flush state that releases the final
// report.
// The walk pauses while a report waits on a stalled result register.
// Reset (async, active low) empties all slots, clears counters and halt.
// Once halted, items are still taken but dropped.
module fault_injection_event_scheduler
  import fies_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  fies_item_if.sink     in_i,
  fies_rpt_if.source    res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_e;

  state_e     state_q, state_d;
  logic       halted_q, halted_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic       pend_vld_q, pend_vld_d;
  report_t    pend_q, pend_d;
  logic       out_vld_q, out_vld_d;
  report_t    out_q, out_d;

  token_t     tok_chain [SLOTS+1];
  slot_wr_t   wr      [SLOTS];
  cell_rpt_t  rpt     [SLOTS];
  logic [SLOTS-1:0] tok_vec;

  logic       in_fire, tick_start, wr_ok, active, shift, go, out_free;
  logic       any_tok, room, is_halt, need_push;
  cell_rpt_t  rep;
  logic [2:0] rep_slot;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign tick_start = in_fire && !halted_q && (in_i.item.kind == KIND_TICK);
  assign wr_ok      = in_fire && !halted_q && (in_i.item.kind == KIND_WRITE);
  assign active     = (in_i.item.profile_a != PROFILE_NONE) ||
                      (in_i.item.profile_b != PROFILE_NONE) ||
                      (in_i.item.profile_c != PROFILE_NONE) ||
                      (in_i.item.profile_d != PROFILE_NONE) ||
                      (in_i.item.profile_e != PROFILE_NONE) ||
                      (in_i.item.profile_f != PROFILE_NONE);

  assign tok_chain[0].vld    = tick_start;
  assign tok_chain[0].active = active;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign wr[i].en  = wr_ok && (in_i.item.slot == 3'(i));
    assign wr[i].cmd = in_i.item.command_word;
    assign wr[i].chk = in_i.item.check_word;
    assign tok_vec[i] = tok_chain[i+1].vld;

    fies_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .wr_i    (wr[i]),
      .tok_i   (tok_chain[i]),
      .tok_o   (tok_chain[i+1]),
      .rpt_o   (rpt[i])
    );
  end

  // at most one cell holds the token, so an OR picks its report
  always_comb begin
    rep      = '0;
    rep_slot = '0;
    any_tok  = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      any_tok = any_tok || tok_vec[i] || rpt[i].vld;
      if (rpt[i].vld) begin
        rep      = rep | rpt[i];
        rep_slot = rep_slot | 3'(i);
      end
    end
  end

  assign out_free  = !out_vld_q || res_o.ready;
  assign room      = (cnt_q < CNT_W'(MAX_RESULTS));
  assign is_halt   = (rep.outcome == OUT_HALT);
  assign need_push = rep.vld && room && pend_vld_q;
  assign go        = !need_push || out_free;
  assign shift     = tick_start || ((state_q == ST_WALK) && go);

  always_comb begin
    state_d    = state_q;
    halted_d   = halted_q;
    cnt_d      = cnt_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    if (out_vld_q && res_o.ready) out_vld_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (tick_start) begin
          state_d    = ST_WALK;
          cnt_d      = '0;
          pend_vld_d = 1'b0;
        end
      end
      ST_WALK: begin
        if (!any_tok) begin
          state_d = ST_FLUSH;
        end else if (rep.vld && go) begin
          if (need_push) begin
            out_d      = pend_q;
            out_d.last = 1'b0;
            out_vld_d  = 1'b1;
          end
          // past the cap only a halt gets in, taking the last place
          if (room || is_halt) begin
            pend_d     = '{event_id: rep.id, outcome: rep.outcome,
                           source_slot: rep_slot, last: 1'b0};
            pend_vld_d = 1'b1;
          end
          if (room) cnt_d = cnt_q + CNT_W'(1);
          if (is_halt) halted_d = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
          out_vld_d  = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      halted_q   <= 1'b0;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      pend_q     <= '0;
      out_q      <= '0;
    end else begin
      state_q    <= state_d;
      halted_q   <= halted_d;
      cnt_q      <= cnt_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      pend_q     <= pend_d;
      out_q      <= out_d;
    end
  end

  assign res_o.valid = out_vld_q;
  assign res_o.rpt   = out_q;

`ifndef SYNTHESIS
  a_tok_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec)) else $error("walk token in more than one cell");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_vld_q) else $error("pending report left in idle");

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RESULTS)) else $error("report count beyond cap");

  a_halt_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.outcome == OUT_HALT)) |-> out_q.last)
    else $error("halt report not marked last");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q) else $error("halt cleared without reset");

  a_no_tick_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (halted_q && (state_q == ST_IDLE)) |=> (state_q == ST_IDLE))
    else $error("walk started while halted");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import fies_pkg::*;

  logic clk_i;
  logic rst_ni;

  fies_item_if req_ch ();
  fies_rpt_if  rpt_ch ();

  fault_injection_event_scheduler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .res_o  (rpt_ch)
  );

  // model of the slot table
  logic [31:0] slot_cmd  [SLOTS];
  logic [31:0] slot_chk  [SLOTS];
  logic [15:0] time_cnt  [SLOTS];
  logic [15:0] cycle_cnt [SLOTS];
  logic        halted_seen;

  item_t   item_q[$];
  report_t pending_reports[$];
  report_t exp_rpt;

  int items_total;
  int items_taken;
  int mismatches;
  int in_gap;
  int out_gap;
  int hold_left;
  bit hold_started;
  logic in_done;

  task automatic log_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [31:0] cmd_word(input logic [15:0] qt, input logic [3:0] ty,
                                           input logic [3:0] st, input logic [5:0] id);
    return {qt, ty, st, 2'b00, id};
  endfunction

  task automatic queue_write(input logic [2:0] s, input logic [31:0] cmd,
                             input logic [31:0] chk);
    item_t        it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it  = raw[$bits(item_t)-1:0];
    it.kind         = KIND_WRITE;
    it.slot         = s;
    it.command_word = cmd;
    it.check_word   = chk;
    item_q.push_back(it);
  endtask

  // profile bytes a..f from high to low
  task automatic queue_tick(input logic [47:0] prof);
    item_t        it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it  = raw[$bits(item_t)-1:0];
    it.kind      = KIND_TICK;
    it.profile_a = prof[47:40];
    it.profile_b = prof[39:32];
    it.profile_c = prof[31:24];
    it.profile_d = prof[23:16];
    it.profile_e = prof[15:8];
    it.profile_f = prof[7:0];
    item_q.push_back(it);
  endtask

  task automatic predict_reports(input item_t it);
    report_t     batch[$];
    report_t     r;
    logic [31:0] w;
    logic [15:0] qt;
    logic        active;
    logic        fire;
    if (halted_seen) return;
    if (it.kind == KIND_WRITE) begin
      if (int'(it.slot) < SLOTS) begin
        slot_cmd[it.slot] = it.command_word;
        slot_chk[it.slot] = it.check_word;
      end
      return;
    end
    active = (it.profile_a != PROFILE_NONE) || (it.profile_b != PROFILE_NONE) ||
             (it.profile_c != PROFILE_NONE) || (it.profile_d != PROFILE_NONE) ||
             (it.profile_e != PROFILE_NONE) || (it.profile_f != PROFILE_NONE);
    for (int i = 0; i < SLOTS; i++) begin
      w = slot_cmd[i];
      if (w == EMPTY_WORD || (w ^ slot_chk[i]) != EMPTY_WORD) continue;
      qt = w[31:16];
      fire = 1'b0;
      r.event_id    = w[5:0];
      r.source_slot = 3'(i);
      r.last        = 1'b0;
      if (w[11:8] == STATUS_QUALIFIED) begin
        if (w[15:12] == TYPE_INSTANT) begin
          fire = 1'b1;
        end else if (w[15:12] == TYPE_AFTER_TIME) begin
          time_cnt[i] = time_cnt[i] + 16'd1;
          if (time_cnt[i] == qt) begin
            fire = 1'b1;
            time_cnt[i] = qt - 16'd1;
          end
        end else if (w[15:12] == TYPE_AFTER_CYCLE && active) begin
          cycle_cnt[i] = cycle_cnt[i] + 16'd1;
          if (cycle_cnt[i] == qt) begin
            fire = 1'b1;
            cycle_cnt[i] = qt - 16'd1;
          end
        end
        if (fire) begin
          if (w[5:0] == WARM_RESET_ID) begin
            // halt always shows up, displacing the last report if full
            if (batch.size() >= MAX_RESULTS) void'(batch.pop_back());
            r.outcome = OUT_HALT;
            batch.push_back(r);
            halted_seen = 1'b1;
            break;
          end
          r.outcome = OUT_FAILED;
          if (batch.size() < MAX_RESULTS) batch.push_back(r);
        end
      end else if (w[11:8] == STATUS_DISQUALIFIED) begin
        r.outcome = OUT_PASSED;
        if (batch.size() < MAX_RESULTS) batch.push_back(r);
        time_cnt[i] = 16'd0;
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[j]) pending_reports.push_back(batch[j]);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sample both channels; check results before predicting the new input
  always @(posedge clk_i) begin
    in_done <= rst_ni && req_ch.valid && req_ch.ready;
    if (rst_ni) begin
      if (rpt_ch.valid && rpt_ch.ready) begin
        if (pending_reports.size() == 0) begin
          log_mismatch($sformatf("unexpected report id %0d outcome %0d slot %0d last %0d",
                       rpt_ch.rpt.event_id, rpt_ch.rpt.outcome, rpt_ch.rpt.source_slot,
                       rpt_ch.rpt.last));
        end else begin
          exp_rpt = pending_reports.pop_front();
          if (rpt_ch.rpt.event_id != exp_rpt.event_id)
            log_mismatch($sformatf("event_id %0d, expected %0d",
                         rpt_ch.rpt.event_id, exp_rpt.event_id));
          if (rpt_ch.rpt.outcome != exp_rpt.outcome)
            log_mismatch($sformatf("outcome %0d, expected %0d",
                         rpt_ch.rpt.outcome, exp_rpt.outcome));
          if (rpt_ch.rpt.source_slot != exp_rpt.source_slot)
            log_mismatch($sformatf("source_slot %0d, expected %0d",
                         rpt_ch.rpt.source_slot, exp_rpt.source_slot));
          if (rpt_ch.rpt.last != exp_rpt.last)
            log_mismatch($sformatf("last %0d, expected %0d slot %0d",
                         rpt_ch.rpt.last, exp_rpt.last, exp_rpt.source_slot));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        items_taken++;
        predict_reports(req_ch.item);
      end
    end
  end

  // item driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || in_done) begin
      if (in_gap > 0) begin
        in_gap--;
        req_ch.valid <= 1'b0;
      end else if (item_q.size() >= 25 && $urandom_range(0, 6) == 0) begin
        in_gap = $urandom_range(0, 4);
        req_ch.valid <= 1'b0;
      end else if (item_q.size() > 0) begin
        req_ch.item  <= item_q.pop_front();
        req_ch.valid <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // one long back-pressure window so the walk stalls and the input backs up
  always @(negedge clk_i) begin
    if (!hold_started && items_taken >= 40) begin
      hold_started = 1'b1;
      hold_left <= 200;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      rpt_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      rpt_ch.ready <= 1'b0;
    end else if (item_q.size() >= 25 && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 4);
      rpt_ch.ready <= 1'b0;
    end else begin
      rpt_ch.ready <= 1'b1;
    end
  end

  initial begin
    logic [31:0] w;
    logic [31:0] chk;
    logic [15:0] qt;
    logic [3:0]  st;
    logic [3:0]  ty;
    logic [5:0]  id;
    logic [2:0]  s;
    logic [47:0] prof;
    int          roll;

    rst_ni        = 1'b0;
    req_ch.valid  = 1'b0;
    req_ch.item   = '0;
    rpt_ch.ready  = 1'b0;
    in_done       = 1'b0;
    items_taken   = 0;
    mismatches    = 0;
    in_gap        = 0;
    out_gap       = 0;
    hold_left     = 0;
    hold_started  = 1'b0;
    halted_seen   = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_cmd[i]  = EMPTY_WORD;
      slot_chk[i]  = '0;
      time_cnt[i]  = '0;
      cycle_cnt[i] = '0;
    end

    // directed: empty tick, field extremes, every status/type, broken slots
    queue_tick(48'hFFFF_FFFF_FFFF);
    w = cmd_word(16'hFFFF, TYPE_INSTANT, STATUS_QUALIFIED, 6'h3F);
    queue_write(3'd0, w, ~w);
    w = cmd_word(16'h0000, TYPE_AFTER_TIME, STATUS_DISQUALIFIED, 6'h00);
    queue_write(3'd1, w, ~w);
    w = cmd_word(16'd2, TYPE_AFTER_TIME, STATUS_QUALIFIED, 6'h05);
    queue_write(3'd2, w, ~w);
    w = cmd_word(16'd3, TYPE_AFTER_CYCLE, STATUS_QUALIFIED, 6'h07);
    queue_write(3'd3, w, ~w);
    w = cmd_word(16'd1, TYPE_INSTANT, STATUS_QUALIFIED, 6'h09);
    queue_write(3'd4, w, w);                       // check word does not match
    w = cmd_word(16'd1, TYPE_INSTANT, 4'h5, 6'h11);
    queue_write(3'd5, w, ~w);                      // unknown status
    w = cmd_word(16'd1, 4'h4, STATUS_QUALIFIED, 6'h12);
    queue_write(3'd6, w, ~w);                      // unknown type
    queue_write(3'd7, EMPTY_WORD, 32'h0);          // empty even though check fits
    queue_tick(48'hFFFF_FFFF_FFFF);
    queue_tick(48'hFFFF_00FF_FFFF);
    queue_tick(48'h0000_0000_0000);
    queue_tick(48'hFFFF_FFFF_FFFE);
    // passed status clears only the time counter; cycle count carries on
    w = cmd_word(16'd3, TYPE_AFTER_CYCLE, STATUS_DISQUALIFIED, 6'h07);
    queue_write(3'd3, w, ~w);
    queue_tick(48'h7FFF_FFFF_FFFF);
    w = cmd_word(16'd3, TYPE_AFTER_CYCLE, STATUS_QUALIFIED, 6'h07);
    queue_write(3'd3, w, ~w);
    queue_tick(48'hFFFF_FFFF_80FF);
    // warm reset id with passed status is an ordinary report
    w = cmd_word(16'd0, TYPE_INSTANT, STATUS_DISQUALIFIED, WARM_RESET_ID);
    queue_write(3'd5, w, ~w);
    w = cmd_word(16'd4, TYPE_INSTANT, STATUS_QUALIFIED, 6'h20);
    queue_write(3'd4, w, ~w);
    w = cmd_word(16'd1, TYPE_INSTANT, STATUS_QUALIFIED, 6'h01);
    queue_write(3'd6, w, ~w);
    w = cmd_word(16'h8000, TYPE_AFTER_TIME, STATUS_QUALIFIED, 6'h3E);
    queue_write(3'd7, w, ~w);
    queue_tick(48'h00FF_FFFF_FFFF);
    queue_tick(48'hFFFF_FFFF_FFFF);

    // random: mostly well-formed slots with short times so counters fire
    for (int k = 0; k < 96; k++) begin
      if ($urandom_range(0, 99) < 38) begin
        roll = $urandom_range(0, 99);
        if (roll < 60) st = STATUS_QUALIFIED;
        else if (roll < 85) st = STATUS_DISQUALIFIED;
        else st = 4'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 30) ty = TYPE_INSTANT;
        else if (roll < 60) ty = TYPE_AFTER_TIME;
        else if (roll < 90) ty = TYPE_AFTER_CYCLE;
        else ty = 4'($urandom);
        if ($urandom_range(0, 9) == 0) qt = 16'($urandom);
        else qt = 16'($urandom_range(1, 5));
        id = 6'($urandom);
        w = cmd_word(qt, ty, st, id);
        w[7:6] = 2'($urandom);
        roll = $urandom_range(0, 99);
        if (roll >= 82 && roll < 96) w = $urandom;
        // keep the warm reset for the closing sequence
        if (w[11:8] == STATUS_QUALIFIED && w[5:0] == WARM_RESET_ID) w[4] = 1'b1;
        if (roll < 90) chk = ~w;
        else if (roll < 96) chk = ~w ^ (32'h1 << $urandom_range(0, 31));
        else begin
          w   = EMPTY_WORD;
          chk = 32'h0;
        end
        s = 3'($urandom);
        queue_write(s, w, chk);
      end else begin
        prof = 48'hFFFF_FFFF_FFFF;
        if ($urandom_range(0, 99) >= 30) begin
          for (int b = 0; b < 6; b++)
            if ($urandom_range(0, 1)) prof[8*b +: 8] = 8'($urandom);
        end
        queue_tick(prof);
      end
    end

    // closing: a full tick ending in the warm reset halt, then ignored items
    for (int k = 0; k < 7; k++) begin
      s = 3'(k);
      if (k % 2 == 0) w = cmd_word(16'd1, TYPE_INSTANT, STATUS_QUALIFIED, 6'h10 + 6'(k));
      else w = cmd_word(16'd1, TYPE_AFTER_TIME, STATUS_DISQUALIFIED, 6'h20 + 6'(k));
      queue_write(s, w, ~w);
    end
    w = cmd_word(16'd1, TYPE_INSTANT, STATUS_QUALIFIED, WARM_RESET_ID);
    queue_write(3'd7, w, ~w);
    queue_tick(48'hFFFF_FFFF_FFFF);
    w = cmd_word(16'd1, TYPE_INSTANT, STATUS_QUALIFIED, 6'h15);
    queue_write(3'd0, w, ~w);
    queue_tick(48'h0000_0000_0000);
    items_total = item_q.size();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (items_taken < items_total) @(posedge clk_i);
    while (pending_reports.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/fies_pkg.sv
hw/rtl/fies_intf.sv
hw/rtl/fies_cell.sv
hw/rtl/fault_injection_event_scheduler.sv
tb/tb.sv
